// ----- sv/ctsp_pkg.sv -----
`timescale 1ns / 1ps

package ctsp_pkg;

  localparam int unsigned SampleW   = 32;
  localparam int unsigned ExtW      = 64;
  localparam int unsigned MhzW      = 10;
  localparam int unsigned PartW     = 10;
  localparam int unsigned DivisorW  = 30;
  localparam int unsigned DivCntW   = 6;
  localparam int unsigned ProdW     = 52;
  localparam int unsigned SmallW    = 20;

  localparam logic [MhzW-1:0] ClockMhzReset = MhzW'(168);
  localparam logic [19:0]     UsPerS        = 20'd1000000;
  localparam logic [9:0]      UsPerMs       = 10'd1000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEC_GO,
    S_SEC_WAIT,
    S_MS_GO,
    S_MS_WAIT,
    S_US_GO,
    S_US_WAIT,
    S_MUL,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ----- sv/ctsp_div.sv -----
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module ctsp_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ctsp_pkg::div_ctrl_t                  ctrl_i,
  input  logic [ctsp_pkg::ExtW-1:0]            dividend_i,
  input  logic [ctsp_pkg::DivisorW-1:0]        divisor_i,
  output ctsp_pkg::div_stat_t                  stat_o,
  output logic [ctsp_pkg::ExtW-1:0]            quotient_o,
  output logic [ctsp_pkg::DivisorW-1:0]        remainder_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [ctsp_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [ctsp_pkg::ExtW-1:0]          quo_q, quo_d;
  logic [ctsp_pkg::DivisorW-1:0]      rem_q, rem_d;
  logic [ctsp_pkg::DivisorW-1:0]      dvs_q, dvs_d;
  logic [ctsp_pkg::DivisorW:0]        trial;
  logic [ctsp_pkg::DivisorW:0]        diff;
  logic                               fits;

  always_comb begin
    trial = {rem_q, quo_q[ctsp_pkg::ExtW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[ctsp_pkg::ExtW-2:0], fits};
      rem_d = fits ? diff[ctsp_pkg::DivisorW-1:0] : trial[ctsp_pkg::DivisorW-1:0];
      cnt_d = cnt_q - ctsp_pkg::DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- sv/cycle_count_timebase_splitter.sv -----
`timescale 1ns / 1ps

// From input accept to result valid: three divisions (seconds, milliseconds, microseconds),
//   each after its start step, then the multiply and output steps.
// The bit-serial divider is shared by all three divisions; a new word is taken once the last
//   result is registered, even while that result waits downstream.
// Reset (async, active low): clock_mhz = 168, previous sample and wrap count zero.
module cycle_count_timebase_splitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ctsp_pkg::MhzW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ctsp_pkg::SampleW-1:0]       counter_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ctsp_pkg::ExtW-1:0]          extended_cycles_o,
  output logic [ctsp_pkg::SampleW-1:0]       whole_seconds_o,
  output logic [ctsp_pkg::PartW-1:0]         millis_part_o,
  output logic [ctsp_pkg::PartW-1:0]         micros_part_o,
  output logic [ctsp_pkg::ExtW-1:0]          total_micros_o,
  output logic                               wrap_seen_o
);

  ctsp_pkg::state_e                     state_q, state_d;
  ctsp_pkg::div_ctrl_t                  div_ctrl;
  ctsp_pkg::div_stat_t                  div_stat;

  logic [ctsp_pkg::MhzW-1:0]            clock_mhz_q;
  logic [ctsp_pkg::SampleW-1:0]         prev_q;
  logic [ctsp_pkg::SampleW-1:0]         wraps_q;
  logic                                 out_valid_q;

  logic [ctsp_pkg::ExtW-1:0]            ext_q;
  logic                                 wrap_q;
  logic [ctsp_pkg::DivisorW-1:0]        per_s_q;
  logic [ctsp_pkg::SmallW-1:0]          per_ms_q;
  logic [ctsp_pkg::MhzW-1:0]            mhz_q;
  logic [ctsp_pkg::SampleW-1:0]         secs_q;
  logic [ctsp_pkg::DivisorW-1:0]        rem_q;
  logic [ctsp_pkg::PartW-1:0]           ms_q;
  logic [ctsp_pkg::PartW-1:0]           us_q;
  logic [ctsp_pkg::ProdW-1:0]           prod_q;
  logic [ctsp_pkg::SmallW-1:0]          part_q;

  logic [ctsp_pkg::ExtW-1:0]            ext_o_q;
  logic [ctsp_pkg::SampleW-1:0]         secs_o_q;
  logic [ctsp_pkg::PartW-1:0]           ms_o_q;
  logic [ctsp_pkg::PartW-1:0]           us_o_q;
  logic [ctsp_pkg::ExtW-1:0]            total_o_q;
  logic                                 wrap_o_q;

  logic [ctsp_pkg::ExtW-1:0]            div_dividend;
  logic [ctsp_pkg::DivisorW-1:0]        div_divisor;
  logic [ctsp_pkg::ExtW-1:0]            div_quo;
  logic [ctsp_pkg::DivisorW-1:0]        div_rem;

  logic                                 in_take;
  logic                                 out_load;
  logic                                 wrapped;
  logic [ctsp_pkg::SampleW-1:0]         wraps_next;
  logic [ctsp_pkg::MhzW-1:0]            mhz_eff;

  assign in_take    = in_valid_i && (state_q == ctsp_pkg::S_IDLE);
  assign in_stall_o = (state_q != ctsp_pkg::S_IDLE);
  assign out_load   = (state_q == ctsp_pkg::S_OUT) && (!out_valid_q || !out_stall_i);
  assign wrapped    = counter_sample_i < prev_q;
  assign wraps_next = wraps_q + ctsp_pkg::SampleW'(wrapped);
  assign mhz_eff    = (clock_mhz_q == '0) ? ctsp_pkg::MhzW'(1) : clock_mhz_q;

  always_comb begin
    state_d        = state_q;
    div_ctrl.start = 1'b0;
    div_dividend   = ext_q;
    div_divisor    = per_s_q;
    unique case (state_q)
      ctsp_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ctsp_pkg::S_SEC_GO;
      end
      ctsp_pkg::S_SEC_GO: begin
        div_ctrl.start = 1'b1;
        state_d        = ctsp_pkg::S_SEC_WAIT;
      end
      ctsp_pkg::S_SEC_WAIT: begin
        if (div_stat.done) state_d = ctsp_pkg::S_MS_GO;
      end
      ctsp_pkg::S_MS_GO: begin
        div_ctrl.start = 1'b1;
        div_dividend   = ctsp_pkg::ExtW'(rem_q);
        div_divisor    = ctsp_pkg::DivisorW'(per_ms_q);
        state_d        = ctsp_pkg::S_MS_WAIT;
      end
      ctsp_pkg::S_MS_WAIT: begin
        if (div_stat.done) state_d = ctsp_pkg::S_US_GO;
      end
      ctsp_pkg::S_US_GO: begin
        div_ctrl.start = 1'b1;
        div_dividend   = ctsp_pkg::ExtW'(rem_q);
        div_divisor    = ctsp_pkg::DivisorW'(mhz_q);
        state_d        = ctsp_pkg::S_US_WAIT;
      end
      ctsp_pkg::S_US_WAIT: begin
        if (div_stat.done) state_d = ctsp_pkg::S_MUL;
      end
      ctsp_pkg::S_MUL: begin
        state_d = ctsp_pkg::S_OUT;
      end
      ctsp_pkg::S_OUT: begin
        if (out_load) state_d = ctsp_pkg::S_IDLE;
      end
      default: begin
        state_d = ctsp_pkg::S_IDLE;
      end
    endcase
  end

  ctsp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctsp_pkg::S_IDLE;
      clock_mhz_q <= ctsp_pkg::ClockMhzReset;
      prev_q      <= '0;
      wraps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) clock_mhz_q <= cfg_wdata_i;
      if (in_take) begin
        prev_q  <= counter_sample_i;
        wraps_q <= wraps_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ext_q    <= {wraps_next, counter_sample_i};
      wrap_q   <= wrapped;
      mhz_q    <= mhz_eff;
      per_s_q  <= ctsp_pkg::DivisorW'(mhz_eff) * ctsp_pkg::DivisorW'(ctsp_pkg::UsPerS);
      per_ms_q <= ctsp_pkg::SmallW'(mhz_eff) * ctsp_pkg::SmallW'(ctsp_pkg::UsPerMs);
    end
    if (div_stat.done) begin
      rem_q <= div_rem;
      unique case (state_q)
        ctsp_pkg::S_SEC_WAIT: secs_q <= div_quo[ctsp_pkg::SampleW-1:0];
        ctsp_pkg::S_MS_WAIT:  ms_q   <= div_quo[ctsp_pkg::PartW-1:0];
        default:              us_q   <= div_quo[ctsp_pkg::PartW-1:0];
      endcase
    end
    if (state_q == ctsp_pkg::S_MUL) begin
      prod_q <= ctsp_pkg::ProdW'(secs_q) * ctsp_pkg::ProdW'(ctsp_pkg::UsPerS);
      part_q <= ctsp_pkg::SmallW'(ms_q) * ctsp_pkg::SmallW'(ctsp_pkg::UsPerMs)
              + ctsp_pkg::SmallW'(us_q);
    end
    if (out_load) begin
      ext_o_q   <= ext_q;
      secs_o_q  <= secs_q;
      ms_o_q    <= ms_q;
      us_o_q    <= us_q;
      total_o_q <= ctsp_pkg::ExtW'(prod_q) + ctsp_pkg::ExtW'(part_q);
      wrap_o_q  <= wrap_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign extended_cycles_o = ext_o_q;
  assign whole_seconds_o   = secs_o_q;
  assign millis_part_o     = ms_o_q;
  assign micros_part_o     = us_o_q;
  assign total_micros_o    = total_o_q;
  assign wrap_seen_o       = wrap_o_q;

endmodule

// ----- test/tb_cycle_count_timebase_splitter.sv -----
`timescale 1ns / 1ps

module tb_cycle_count_timebase_splitter;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 1500;
  localparam int TailCycles = 250;
  localparam int BurstWords = 213;

  typedef struct packed {
    logic [ctsp_pkg::ExtW-1:0]    ext;
    logic [ctsp_pkg::SampleW-1:0] secs;
    logic [ctsp_pkg::PartW-1:0]   ms;
    logic [ctsp_pkg::PartW-1:0]   us;
    logic [ctsp_pkg::ExtW-1:0]    total;
    logic                         wrap;
  } split_t;

  class timebase_scoreboard;
    logic [ctsp_pkg::MhzW-1:0]    clock_mhz;
    logic [ctsp_pkg::SampleW-1:0] last_sample;
    logic [ctsp_pkg::SampleW-1:0] wrap_count;
    split_t                       split_q[$];
    int                           mismatches;

    function new();
      clock_mhz   = ctsp_pkg::ClockMhzReset;
      last_sample = '0;
      wrap_count  = '0;
      mismatches  = 0;
    endfunction

    function void set_clock(logic [ctsp_pkg::MhzW-1:0] v);
      clock_mhz = v;
    endfunction

    function int pending();
      return split_q.size();
    endfunction

    function void note_sample(logic [ctsp_pkg::SampleW-1:0] s);
      logic [ctsp_pkg::ExtW-1:0] mhz, per_s, per_ms, secs, rem, msv, usv, secs32;
      split_t e;
      mhz    = (clock_mhz == '0) ? 64'd1 : 64'(clock_mhz);
      per_s  = mhz * 64'(ctsp_pkg::UsPerS);
      per_ms = mhz * 64'(ctsp_pkg::UsPerMs);
      e.wrap = (s < last_sample);
      if (e.wrap) begin
        wrap_count = wrap_count + 32'd1;
      end
      last_sample = s;
      e.ext   = {wrap_count, s};
      secs    = e.ext / per_s;
      rem     = e.ext - secs * per_s;
      msv     = rem / per_ms;
      rem     = rem - msv * per_ms;
      usv     = rem / mhz;
      secs32  = {32'd0, secs[31:0]};
      e.secs  = secs[31:0];
      e.ms    = msv[ctsp_pkg::PartW-1:0];
      e.us    = usv[ctsp_pkg::PartW-1:0];
      e.total = secs32 * 64'(ctsp_pkg::UsPerS) + msv * 64'(ctsp_pkg::UsPerMs) + usv;
      split_q.push_back(e);
    endfunction

    function void check_result(split_t got);
      split_t e;
      if (split_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: ext=%h secs=%0d", got.ext, got.secs);
        end
        return;
      end
      e = split_q.pop_front();
      if (got.ext !== e.ext || got.secs !== e.secs || got.ms !== e.ms ||
          got.us !== e.us || got.total !== e.total || got.wrap !== e.wrap) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: ext=%h secs=%0d ms=%0d us=%0d total=%0d wrap=%b",
                   e.ext, e.secs, e.ms, e.us, e.total, e.wrap);
          $display("         got: ext=%h secs=%0d ms=%0d us=%0d total=%0d wrap=%b",
                   got.ext, got.secs, got.ms, got.us, got.total, got.wrap);
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [ctsp_pkg::MhzW-1:0]     cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [ctsp_pkg::SampleW-1:0]  counter_sample_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [ctsp_pkg::ExtW-1:0]     extended_cycles_o;
  logic [ctsp_pkg::SampleW-1:0]  whole_seconds_o;
  logic [ctsp_pkg::PartW-1:0]    millis_part_o;
  logic [ctsp_pkg::PartW-1:0]    micros_part_o;
  logic [ctsp_pkg::ExtW-1:0]     total_micros_o;
  logic                          wrap_seen_o;

  timebase_scoreboard sb = new();

  int                            tx_idle_pct;
  int                            rx_idle_pct;
  int                            hold_left;
  int                            quiet_cycles;
  logic [ctsp_pkg::SampleW-1:0]  last_sent;
  logic [ctsp_pkg::MhzW-1:0]     seg_clock [6];

  cycle_count_timebase_splitter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .counter_sample_i  (counter_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .extended_cycles_o (extended_cycles_o),
    .whole_seconds_o   (whole_seconds_o),
    .millis_part_o     (millis_part_o),
    .micros_part_o     (micros_part_o),
    .total_micros_o    (total_micros_o),
    .wrap_seen_o       (wrap_seen_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(counter_sample_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result('{extended_cycles_o, whole_seconds_o, millis_part_o,
                          micros_part_o, total_micros_o, wrap_seen_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no word moved in %0d cycles", StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [ctsp_pkg::SampleW-1:0] s);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    counter_sample_i <= s;
    last_sent        = s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_clock(input logic [ctsp_pkg::MhzW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_clock(v);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly rising runs with random steps (wraps arise naturally), some noise
  task automatic random_burst(input int count);
    int                           left;
    int                           run;
    int                           kind;
    logic [ctsp_pkg::SampleW-1:0] step;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9, 0) < 8) begin
        run  = $urandom_range(20, 4);
        kind = $urandom_range(2, 0);
        for (int k = 0; k < run && left > 0; k++) begin
          case (kind)
            0:       step = $urandom_range(1000, 0);
            1:       step = $urandom_range(32'h00FF_FFFF, 0);
            default: step = $urandom;
          endcase
          send_sample(last_sent + step);
          left--;
        end
      end else begin
        send_sample($urandom);
        left--;
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    counter_sample_i = '0;
    tx_idle_pct      = 29;
    rx_idle_pct      = 55;
    hold_left        = 0;
    quiet_cycles     = 0;
    last_sent        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset clock; equal samples, wraps at the counter extremes
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'hFFFF_FFFE);
    send_sample(32'h0000_0005);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    // zero clock counts as 1 MHz
    settle();
    write_clock(10'd0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'd999999);
    send_sample(32'd1000000);
    // clock above range
    settle();
    write_clock(10'd1023);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_000A);
    settle();
    write_clock(10'd1000);
    send_sample(32'h1234_5678);
    send_sample(32'h0000_0000);
    settle();
    write_clock(10'd1);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);

    seg_clock[0] = 10'd168;
    seg_clock[1] = 10'd1023;
    seg_clock[2] = 10'd1;
    seg_clock[3] = 10'd1000;
    seg_clock[4] = 10'd0;
    seg_clock[5] = ctsp_pkg::MhzW'($urandom_range(1023, 0));

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin tx_idle_pct = 29; rx_idle_pct = 55; end
        1: begin tx_idle_pct = 55; rx_idle_pct = 29; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        settle();
        write_clock(seg_clock[2 * m + seg]);
        if (m == 2 && seg == 0) begin
          hold_left = HoldCycles;
        end
        random_burst(BurstWords);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() == 0 && sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ctsp_pkg.sv
sv/ctsp_div.sv
sv/cycle_count_timebase_splitter.sv
test/tb_cycle_count_timebase_splitter.sv
